>>> design/sjfq_pkg.sv
// ----------------------------------------------------------------------------
// sjfq_pkg
// Types and codes shared by the shortest-job-first queue and its cells.
// ----------------------------------------------------------------------------
package sjfq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  localparam logic [1:0] STAT_INSERTED = 2'd0;
  localparam logic [1:0] STAT_DROPPED  = 2'd1;
  localparam logic [1:0] STAT_POPPED   = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  typedef struct packed {
    logic        action;
    logic [15:0] job_id;
    logic [15:0] job_size;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [15:0] out_size;
    logic [4:0]  queued;
    logic [31:0] work_served;
    logic [31:0] jobs_served;
  } out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] size;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   new_entry;
  } cell_ctrl_t;

endpackage

>>> design/shortest_job_first_queue_top.sv
// ----------------------------------------------------------------------------
// shortest_job_first_queue_top
// Bounded job queue kept in ascending order of size, equal sizes in arrival
// order. Takes one insert or pop transaction per clock: busy stays low, and
// each result is strobed on out_strobe in the cycle after start. The figure is
// set by the row of cells, which all compare their key with the new job in
// parallel and shift in the same cycle. No clearing pass is needed after
// reset. Results cannot be held off, so the receiver must take every strobe.
// ----------------------------------------------------------------------------
module shortest_job_first_queue_top #(
  parameter int QUEUE_DEPTH = sjfq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  sjfq_pkg::in_t   in_item,
  output logic            out_strobe,
  output sjfq_pkg::out_t  out_item
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]    fill_r;
  logic [CW-1:0]    fill_nxt;
  logic [31:0]      work_r;
  logic [31:0]      work_nxt;
  logic [31:0]      jobs_r;
  logic [31:0]      jobs_nxt;
  logic             out_strobe_r;
  sjfq_pkg::out_t   out_item_r;
  sjfq_pkg::out_t   out_item_nxt;

  logic             accept;
  logic             full;
  logic             empty;
  logic [32:0]      work_sum;
  logic [CW+4:0]    fill_ext;
  sjfq_pkg::cell_ctrl_t ctrl;

  logic             place    [QUEUE_DEPTH];
  sjfq_pkg::entry_t entries  [QUEUE_DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (fill_r == CW'(QUEUE_DEPTH));
  assign empty  = (fill_r == '0);

  always_comb begin
    ctrl.new_entry.id   = in_item.job_id;
    ctrl.new_entry.size = in_item.job_size;
    ctrl.op             = sjfq_pkg::OP_HOLD;
    if (accept) begin
      if (in_item.action == sjfq_pkg::ACT_POP) begin
        if (!empty) begin
          ctrl.op = sjfq_pkg::OP_POP;
        end
      end else if (!full) begin
        ctrl.op = sjfq_pkg::OP_INSERT;
      end
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic             occ;
    logic             pl;
    sjfq_pkg::entry_t le;
    sjfq_pkg::entry_t re;

    assign occ = (CW'(i) < fill_r);

    if (i == 0) begin : g_head
      assign pl = 1'b0;
      assign le = ctrl.new_entry;
    end else begin : g_body
      assign pl = place[i-1];
      assign le = entries[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign re = entries[i];
    end else begin : g_mid
      assign re = entries[i+1];
    end

    sjfq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ),
      .place_left  (pl),
      .left_entry  (le),
      .right_entry (re),
      .place       (place[i]),
      .entry       (entries[i])
    );
  end

  assign work_sum = {1'b0, work_r} + 33'(entries[0].size);

  always_comb begin
    fill_nxt = fill_r;
    work_nxt = work_r;
    jobs_nxt = jobs_r;
    case (ctrl.op)
      sjfq_pkg::OP_INSERT: begin
        fill_nxt = fill_r + CW'(1);
      end
      sjfq_pkg::OP_POP: begin
        fill_nxt = fill_r - CW'(1);
        work_nxt = work_sum[32] ? 32'hFFFF_FFFF : work_sum[31:0];
        jobs_nxt = (jobs_r == 32'hFFFF_FFFF) ? jobs_r : jobs_r + 32'd1;
      end
      default: begin
        fill_nxt = fill_r;
      end
    endcase
  end

  assign fill_ext = (CW+5)'(fill_nxt);

  always_comb begin
    out_item_nxt.out_id      = '0;
    out_item_nxt.out_size    = '0;
    out_item_nxt.queued      = fill_ext[4:0];
    out_item_nxt.work_served = work_nxt;
    out_item_nxt.jobs_served = jobs_nxt;
    if (in_item.action == sjfq_pkg::ACT_POP) begin
      out_item_nxt.status = empty ? sjfq_pkg::STAT_EMPTY : sjfq_pkg::STAT_POPPED;
      if (!empty) begin
        out_item_nxt.out_id   = entries[0].id;
        out_item_nxt.out_size = entries[0].size;
      end
    end else begin
      out_item_nxt.status = full ? sjfq_pkg::STAT_DROPPED : sjfq_pkg::STAT_INSERTED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      work_r       <= '0;
      jobs_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      fill_r       <= fill_nxt;
      work_r       <= work_nxt;
      jobs_r       <= jobs_nxt;
      out_strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // fill count stays within the row
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  // every transaction gives one result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("transaction without result");

  // a pop from a non-empty queue removes exactly one job
  a_pop_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == sjfq_pkg::OP_POP) |=> (fill_r == $past(fill_r) - CW'(1)))
    else $error("pop did not shrink the queue");

  // a popped result always has a nonzero job count
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status == sjfq_pkg::STAT_POPPED) |-> (out_item.jobs_served != '0))
    else $error("popped job not counted");

endmodule

>>> design/sjfq_cell.sv
// ----------------------------------------------------------------------------
// sjfq_cell
// One slot of the sorted job row: compares its key with the incoming job and
// shifts toward or away from the head together with its neighbors.
// ----------------------------------------------------------------------------
module sjfq_cell (
  input  logic                clk,
  input  sjfq_pkg::cell_ctrl_t ctrl,
  input  logic                occ,
  input  logic                place_left,
  input  sjfq_pkg::entry_t    left_entry,
  input  sjfq_pkg::entry_t    right_entry,
  output logic                place,
  output sjfq_pkg::entry_t    entry
);

  sjfq_pkg::entry_t entry_r;
  sjfq_pkg::entry_t entry_nxt;

  // new job goes behind every entry of smaller or equal size
  assign place = !occ || (entry_r.size > ctrl.new_entry.size);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      sjfq_pkg::OP_INSERT: begin
        if (place) begin
          entry_nxt = place_left ? left_entry : ctrl.new_entry;
        end
      end
      sjfq_pkg::OP_POP: begin
        entry_nxt = right_entry;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shortest-job-first queue. A driver sends
// insert and pop commands from a pending list with random idle bursts, and
// keeps its own sorted job list to work out each expected result. A monitor
// checks every strobed result against the oldest expected one. A directed
// opening covers the empty pop, full drop, equal sizes and size extremes.
// Random traffic follows. A short run with no idling closes the test.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int QDEPTH       = sjfq_pkg::DEFAULT_QUEUE_DEPTH;
  localparam int RANDOM_JOBS  = 1500;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    sjfq_pkg::in_t job;
    int unsigned   gap;
  } job_cmd_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  sjfq_pkg::in_t  in_item = '0;
  logic           out_strobe;
  sjfq_pkg::out_t out_item;

  job_cmd_t       job_cmd_q[$];
  sjfq_pkg::out_t outcome_q[$];
  int unsigned    gap_left = 0;
  int unsigned    err_count = 0;
  int unsigned    stall_cycles = 0;

  // scoreboard copy of the sorted job list
  logic [15:0] held_id[QDEPTH];
  logic [15:0] held_size[QDEPTH];
  int          held_count = 0;
  logic [31:0] work_total = '0;
  logic [31:0] job_total = '0;

  shortest_job_first_queue_top #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic sjfq_pkg::out_t schedule_job(input sjfq_pkg::in_t job);
    sjfq_pkg::out_t res;
    int             pos;
    int             k;
    res = '0;
    if (job.action == sjfq_pkg::ACT_INSERT) begin
      if (held_count >= QDEPTH) begin
        res.status = sjfq_pkg::STAT_DROPPED;
      end else begin
        pos = 0;
        while (pos < held_count && held_size[pos] <= job.job_size) pos++;
        for (k = held_count; k > pos; k--) begin
          held_id[k]   = held_id[k - 1];
          held_size[k] = held_size[k - 1];
        end
        held_id[pos]   = job.job_id;
        held_size[pos] = job.job_size;
        held_count++;
        res.status = sjfq_pkg::STAT_INSERTED;
      end
    end else begin
      if (held_count == 0) begin
        res.status = sjfq_pkg::STAT_EMPTY;
      end else begin
        res.out_id   = held_id[0];
        res.out_size = held_size[0];
        for (k = 1; k < held_count; k++) begin
          held_id[k - 1]   = held_id[k];
          held_size[k - 1] = held_size[k];
        end
        held_count--;
        work_total = sat_add(work_total, {16'd0, res.out_size});
        job_total  = sat_add(job_total, 32'd1);
        res.status = sjfq_pkg::STAT_POPPED;
      end
    end
    res.queued      = held_count[4:0];
    res.work_served = work_total;
    res.jobs_served = job_total;
    return res;
  endfunction

  task automatic queue_job(input logic act, input logic [15:0] id, input logic [15:0] size,
                           input int unsigned gap);
    job_cmd_t c;
    c.job.action   = act;
    c.job.job_id   = id;
    c.job.job_size = size;
    c.gap          = gap;
    job_cmd_q.insert(job_cmd_q.size(), c);
  endtask

  function automatic int unsigned pick_gap(input bit idling);
    if (idling && $urandom_range(0, 99) < 30) return $urandom_range(1, 11);
    return 0;
  endfunction

  function automatic logic [15:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(0, 7));
    if (r < 80) return 16'($urandom);
    return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      err_count++;
      if (err_count <= 50)
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
    end
  endtask

  // driver
  always @(posedge clk) begin
    job_cmd_t c;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) outcome_q.insert(outcome_q.size(), schedule_job(in_item));
      if (!start || !busy) begin
        if (gap_left != 0) begin
          start <= 1'b0;
          gap_left--;
        end else if (job_cmd_q.size() != 0) begin
          c = job_cmd_q[0];
          job_cmd_q.delete(0);
          in_item  <= c.job;
          start    <= 1'b1;
          gap_left = c.gap;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    sjfq_pkg::out_t exp_r;
    if (rst_n) begin
      if ($isunknown(out_strobe)) begin
        err_count++;
        if (err_count <= 50)
          $display("%0t: out_strobe unknown: expected 0 or 1, actual %b", $time, out_strobe);
      end else if (out_strobe) begin
        if (outcome_q.size() == 0) begin
          err_count++;
          if (err_count <= 50)
            $display("%0t: unexpected transaction: expected none, actual %p", $time, out_item);
        end else begin
          exp_r = outcome_q[0];
          outcome_q.delete(0);
          check_field("status", 32'(exp_r.status), 32'(out_item.status));
          check_field("out_id", 32'(exp_r.out_id), 32'(out_item.out_id));
          check_field("out_size", 32'(exp_r.out_size), 32'(out_item.out_size));
          check_field("queued", 32'(exp_r.queued), 32'(out_item.queued));
          check_field("work_served", exp_r.work_served, out_item.work_served);
          check_field("jobs_served", exp_r.jobs_served, out_item.jobs_served);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe === 1'b1) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int          n;
    int          k;
    int unsigned ins_pct;
    bit          idling;
    // directed opening
    queue_job(sjfq_pkg::ACT_POP, 16'hFFFF, 16'hFFFF, 0);
    queue_job(sjfq_pkg::ACT_INSERT, 16'h0000, 16'hFFFF, 2);
    queue_job(sjfq_pkg::ACT_INSERT, 16'hFFFF, 16'h0000, 0);
    queue_job(sjfq_pkg::ACT_INSERT, 16'h1234, 16'h0005, 0);
    queue_job(sjfq_pkg::ACT_INSERT, 16'h0001, 16'h0005, 1);
    queue_job(sjfq_pkg::ACT_INSERT, 16'h0002, 16'h0005, 0);
    queue_job(sjfq_pkg::ACT_INSERT, 16'hAAAA, 16'h0000, 0);
    queue_job(sjfq_pkg::ACT_INSERT, 16'h5555, 16'hFFFF, 11);
    for (k = 0; k < 9; k++)
      queue_job(sjfq_pkg::ACT_INSERT, 16'(16'h0100 + k), 16'(k * 7 + 1), 0);
    queue_job(sjfq_pkg::ACT_INSERT, 16'hFFFF, 16'h0001, 0);
    for (k = 0; k < 6; k++)
      queue_job(sjfq_pkg::ACT_POP, 16'($urandom), 16'($urandom), k % 2);

    // random traffic in blocks of varying mix and idling
    n = 0;
    while (n < RANDOM_JOBS) begin
      case ($urandom_range(0, 2))
        0: ins_pct = 80;
        1: ins_pct = 25;
        default: ins_pct = 50;
      endcase
      idling = ($urandom_range(0, 99) < 60);
      for (k = 0; k < 30; k++) begin
        if ($urandom_range(0, 99) < ins_pct)
          queue_job(sjfq_pkg::ACT_INSERT, 16'($urandom), pick_size(), pick_gap(idling));
        else
          queue_job(sjfq_pkg::ACT_POP, 16'($urandom), 16'($urandom), pick_gap(idling));
        n++;
      end
    end

    // closing run with no idling
    for (k = 0; k < 40; k++)
      queue_job($urandom_range(0, 1) != 0 ? sjfq_pkg::ACT_POP : sjfq_pkg::ACT_INSERT,
                16'($urandom), pick_size(), 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (job_cmd_q.size() != 0 || start || outcome_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
